@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AWD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AWD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/awd_pkg.sv @@
`default_nettype none

package awd_pkg;

    typedef enum logic [1:0] {
        MODE_TUBE = 2'd0,
        MODE_SOFT = 2'd1,
        MODE_HARD = 2'd2,
        MODE_FUZZ = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_DRIVE    = 3'd1,
        REG_MIX      = 3'd2,
        REG_IN_GAIN  = 3'd3,
        REG_OUT_GAIN = 3'd4
    } reg_idx_t;

    typedef struct packed {
        mode_t       mode;
        logic [13:0] drive;
        logic [15:0] mix;
        logic [15:0] in_gain;
        logic [15:0] out_gain;
    } cfg_t;

    localparam logic [13:0] DRIVE_RESET    = 14'd1280;
    localparam logic [15:0] MIX_RESET      = 16'd32768;
    localparam logic [15:0] IN_GAIN_RESET  = 16'd16384;
    localparam logic [15:0] OUT_GAIN_RESET = 16'd16384;
    localparam logic [15:0] MIX_ONE        = 16'd32768;
    localparam logic [63:0] ONE40          = 64'd1 << 40;

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        p = p + (128'd1 << (sh - 1));
        return 64'(p >> sh);
    endfunction

    // shift-subtract divide: remainder in the upper half, quotient in the lower half
    function automatic logic [127:0] udivmod(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b})
            begin
                r = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return {r[63:0], q};
    endfunction

    function automatic logic [63:0] exp_neg(logic [63:0] v);
        logic [63:0]  s;
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] qr;
        s = (v + 64'd16) >> 5;
        sum = ONE40;
        term = ONE40;
        for (int k = 1; k <= 16; k++)
        begin
            qr = udivmod(mul_shift(term, s, 40), 64'(k));
            term = qr[63:0];
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int k = 0; k < 5; k++)
        begin
            sum = mul_shift(sum, sum, 40);
        end
        return sum;
    endfunction

    function automatic logic [63:0] tanh_q44(logic [63:0] e2);
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  q1;
        logic [63:0]  r;
        logic [127:0] qr;
        num = ONE40 - e2;
        den = ONE40 + e2;
        qr = udivmod(num << 22, den);
        q1 = qr[63:0];
        r = qr[127:64];
        qr = udivmod(r << 22, den);
        return (q1 << 22) + qr[63:0];
    endfunction

    function automatic logic [63:0] round_q40(logic [63:0] e, int f);
        return (e + (64'd1 << (39 - f))) >> (40 - f);
    endfunction

    function automatic logic [63:0] round_q44(logic [63:0] q, int f);
        return (q + (64'd1 << (43 - f))) >> (44 - f);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/awd_in_if.sv @@
`default_nettype none

interface awd_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/awd_out_if.sv @@
`default_nettype none

interface awd_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/awd_ram.sv @@
`default_nettype none

module awd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/awd_regs.sv @@
`default_nettype none

`include "assert_macros.svh"

module awd_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output awd_pkg::cfg_t     cfg
);

    awd_pkg::cfg_t     cfg_reg;
    awd_pkg::cfg_t     cfg_next;
    awd_pkg::reg_idx_t idx;
    logic              wr;

    assign idx    = awd_pkg::reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                awd_pkg::REG_MODE:     cfg_next.mode = awd_pkg::mode_t'(pwdata[1:0]);
                awd_pkg::REG_DRIVE:    cfg_next.drive = pwdata[13:0];
                awd_pkg::REG_MIX:      cfg_next.mix = pwdata[15:0];
                awd_pkg::REG_IN_GAIN:  cfg_next.in_gain = pwdata[15:0];
                awd_pkg::REG_OUT_GAIN: cfg_next.out_gain = pwdata[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            awd_pkg::REG_MODE:     prdata = {30'd0, cfg_reg.mode};
            awd_pkg::REG_DRIVE:    prdata = {18'd0, cfg_reg.drive};
            awd_pkg::REG_MIX:      prdata = {16'd0, cfg_reg.mix};
            awd_pkg::REG_IN_GAIN:  prdata = {16'd0, cfg_reg.in_gain};
            awd_pkg::REG_OUT_GAIN: prdata = {16'd0, cfg_reg.out_gain};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= awd_pkg::MODE_TUBE;
            cfg_reg.drive    <= awd_pkg::DRIVE_RESET;
            cfg_reg.mix      <= awd_pkg::MIX_RESET;
            cfg_reg.in_gain  <= awd_pkg::IN_GAIN_RESET;
            cfg_reg.out_gain <= awd_pkg::OUT_GAIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    `AWD_ASSERT_NXT(a_drive_write, clk, rst_n, wr && idx == awd_pkg::REG_DRIVE, cfg_reg.drive == $past(pwdata[13:0]))

endmodule

`default_nettype wire

@@ hw/rtl/awd_curve.sv @@
`default_nettype none

module awd_curve #(
    parameter int CURVE_TABLE_ENTRIES = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   rd_en,
    input  wire logic [$clog2(CURVE_TABLE_ENTRIES)-1:0] rd_addr,
    output logic      [2*SAMPLE_BITS-1:0]               tanh_pair,
    output logic      [2*SAMPLE_BITS-1:0]               exp_pair,
    output logic      [SAMPLE_BITS-1:0]                 tanh_last,
    output logic      [SAMPLE_BITS-1:0]                 exp_last,
    output logic                                        busy
);

    localparam int N  = CURVE_TABLE_ENTRIES;
    localparam int SB = SAMPLE_BITS;
    localparam int F  = SAMPLE_BITS - 1;
    localparam int AW = $clog2(CURVE_TABLE_ENTRIES);

    localparam logic [63:0] VL = (64'(N) << 44) / 64'(N);
    localparam logic [63:0] WL = (64'(N) << 45) / 64'(N);
    localparam logic [SB-1:0] EXP_LAST =
        SB'(awd_pkg::round_q40(awd_pkg::exp_neg(VL), F));
    localparam logic [SB-1:0] TANH_LAST =
        SB'(awd_pkg::round_q44(awd_pkg::tanh_q44(awd_pkg::exp_neg(WL)), F));

    logic [2*SB-1:0] tanh_rom [N];
    logic [2*SB-1:0] exp_rom  [N];

    for (genvar g = 0; g < N; g++)
    begin : g_rom
        localparam logic [63:0] V0 = (64'(g) << 44) / 64'(N);
        localparam logic [63:0] V1 = (64'(g + 1) << 44) / 64'(N);
        localparam logic [63:0] W0 = (64'(g) << 45) / 64'(N);
        localparam logic [63:0] W1 = (64'(g + 1) << 45) / 64'(N);
        localparam logic [SB-1:0] E0 = SB'(awd_pkg::round_q40(awd_pkg::exp_neg(V0), F));
        localparam logic [SB-1:0] E1 = SB'(awd_pkg::round_q40(awd_pkg::exp_neg(V1), F));
        localparam logic [SB-1:0] T0 =
            SB'(awd_pkg::round_q44(awd_pkg::tanh_q44(awd_pkg::exp_neg(W0)), F));
        localparam logic [SB-1:0] T1 =
            SB'(awd_pkg::round_q44(awd_pkg::tanh_q44(awd_pkg::exp_neg(W1)), F));
        assign exp_rom[g]  = {E1, E0};
        assign tanh_rom[g] = {T1, T0};
    end

    logic [AW-1:0] fill_cnt_reg;
    logic [AW-1:0] fill_cnt_next;
    logic          busy_reg;
    logic          busy_next;

    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            fill_cnt_next = fill_cnt_reg + AW'(1);
            if (fill_cnt_reg == AW'(N - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            fill_cnt_reg <= fill_cnt_next;
            busy_reg     <= busy_next;
        end
    end

    awd_ram #(.WIDTH(2 * SB), .DEPTH(N)) u_tanh_ram (
        .clk   (clk),
        .we    (busy_reg),
        .waddr (fill_cnt_reg),
        .wdata (tanh_rom[fill_cnt_reg]),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (tanh_pair)
    );

    awd_ram #(.WIDTH(2 * SB), .DEPTH(N)) u_exp_ram (
        .clk   (clk),
        .we    (busy_reg),
        .waddr (fill_cnt_reg),
        .wdata (exp_rom[fill_cnt_reg]),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (exp_pair)
    );

    assign tanh_last = TANH_LAST;
    assign exp_last  = EXP_LAST;
    assign busy      = busy_reg;

endmodule

`default_nettype wire

@@ hw/rtl/audio_waveshaper_distortion.sv @@
`default_nettype none

`include "assert_macros.svh"

// Waveshaping distortion: one signed sample in, one shaped sample out, one item per
// clock once running and while the output is not stalled. The datapath is a ten-stage
// pipeline (input gain, drive and square, table address and cube, curve read,
// interpolation product and fuzz drive, shaping select, mix, mix rounding, output
// gain, round and saturate); a stall holds each stage and bubbles close up. After
// reset the tanh and exp curve memories are filled one entry per cycle, all
// CURVE_TABLE_ENTRIES entries, and din.ready stays low until that pass ends.
// Registers must be written over the APB port only while no sample is in flight;
// the user is bound by this, and the block itself does not enforce it.
module audio_waveshaper_distortion #(
    parameter int CURVE_TABLE_ENTRIES = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    awd_in_if.sink           din,
    awd_out_if.source        dout,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int N    = CURVE_TABLE_ENTRIES;
    localparam int SB   = SAMPLE_BITS;
    localparam int F    = SAMPLE_BITS - 1;
    localparam int AW   = $clog2(CURVE_TABLE_ENTRIES);
    localparam int NB   = $clog2(CURVE_TABLE_ENTRIES + 1);
    localparam int PW   = F + 4 + NB;
    localparam int CW   = SB + 2;
    localparam int P1W  = SB + 17;
    localparam int P2W  = CW + 15;
    localparam int XW   = SB + 9;
    localparam int CCW  = SB + 5;
    localparam int PCW  = 2 * CW;
    localparam int CCCW = SB + 7;
    localparam int PQW  = CCW + CW;
    localparam int PFW  = CCCW + 15;
    localparam int YW   = SB + 13;
    localparam int DW   = SB + 1;
    localparam int PDW  = SB + 18;
    localparam int IW   = SB + 2;
    localparam int ACW  = SB + 31;
    localparam int A2W  = SB + 16;
    localparam int POW  = SB + 33;
    localparam int RSW  = SB + 19;
    localparam int NST  = 10;

    awd_pkg::cfg_t cfg;
    logic          filling;

    awd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [NST:1] v_reg;
    logic [NST:1] v_next;
    logic [NST:1] en;

    always_comb
    begin
        en[NST] = !v_reg[NST] || dout.ready;
        for (int k = NST - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign din.ready = en[1] && !filling;

    always_comb
    begin
        v_next = v_reg;
        if (en[1])
        begin
            v_next[1] = din.valid && !filling;
        end
        for (int k = 2; k <= NST; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage 1: input gain
    logic signed [P1W-1:0] p1;
    logic        [P1W-1:0] m1;
    logic        [P1W-1:0] r1;
    logic signed [CW-1:0]  c1_next;
    logic signed [CW-1:0]  c1_reg;

    always_comb
    begin
        p1 = $signed(din.sample_in) * $signed({1'b0, cfg.in_gain});
        m1 = p1[P1W-1] ? -p1 : p1;
        r1 = (m1 + (P1W'(1) << 13)) >> 14;
        c1_next = CW'(p1[P1W-1] ? -r1 : r1);
    end

    // stage 2: drive and square
    logic signed [P2W-1:0] p2;
    logic        [P2W-1:0] m2;
    logic        [P2W-1:0] r2;
    logic signed [PCW-1:0] pc;
    logic        [PCW-1:0] pcu;
    logic signed [XW-1:0]  x2_next;
    logic signed [CCW-1:0] cc2_next;
    logic signed [XW-1:0]  x2_reg;
    logic signed [CW-1:0]  c2_reg;
    logic signed [CCW-1:0] cc2_reg;

    always_comb
    begin
        p2 = c1_reg * $signed({1'b0, cfg.drive});
        m2 = p2[P2W-1] ? -p2 : p2;
        r2 = (m2 + (P2W'(1) << 7)) >> 8;
        x2_next = XW'(p2[P2W-1] ? -r2 : r2);
        pc = c1_reg * c1_reg;
        pcu = pc;
        cc2_next = CCW'((pcu + (PCW'(1) << (F - 1))) >> F);
    end

    // stage 3: table address and cube
    logic        [XW-1:0]   u3;
    logic        [PW-1:0]   p3;
    logic signed [PQW-1:0]  pq;
    logic        [PQW-1:0]  mq;
    logic        [PQW-1:0]  rq;
    logic        [AW-1:0]   idx3_next;
    logic        [15:0]     f16_3_next;
    logic                   big3_next;
    logic signed [CCCW-1:0] ccc3_next;
    logic        [AW-1:0]   idx3_reg;
    logic        [15:0]     f16_3_reg;
    logic                   big3_reg;
    logic signed [XW-1:0]   x3_reg;
    logic signed [CW-1:0]   c3_reg;
    logic signed [CCCW-1:0] ccc3_reg;

    always_comb
    begin
        u3 = x2_reg[XW-1] ? -x2_reg : x2_reg;
        big3_next = |u3[XW-1:F+4];
        p3 = PW'(u3[F+3:0]) * PW'(N);
        idx3_next = p3[F+4 +: AW];
        f16_3_next = p3[F+3 -: 16];
        pq = cc2_reg * c2_reg;
        mq = pq[PQW-1] ? -pq : pq;
        rq = (mq + (PQW'(1) << (F - 1))) >> F;
        ccc3_next = CCCW'(pq[PQW-1] ? -rq : rq);
    end

    // stage 4: curve read, fuzz drive
    logic [2*SB-1:0] tanh_pair;
    logic [2*SB-1:0] exp_pair;
    logic [SB-1:0]   tanh_last;
    logic [SB-1:0]   exp_last;

    awd_curve #(.CURVE_TABLE_ENTRIES(N), .SAMPLE_BITS(SB)) u_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (en[4]),
        .rd_addr   (idx3_reg),
        .tanh_pair (tanh_pair),
        .exp_pair  (exp_pair),
        .tanh_last (tanh_last),
        .exp_last  (exp_last),
        .busy      (filling)
    );

    logic        [15:0]     f16_4_reg;
    logic                   big4_reg;
    logic signed [XW-1:0]   x4_reg;
    logic signed [CW-1:0]   c4_reg;
    logic signed [CCCW-1:0] ccc4_reg;

    logic        [2*SB-1:0] pair4;
    logic        [SB-1:0]   last4;
    logic        [SB-1:0]   base5_next;
    logic signed [DW-1:0]   d4;
    logic signed [PDW-1:0]  pd5_next;
    logic signed [PFW-1:0]  pf;
    logic        [PFW-1:0]  mf;
    logic        [PFW-1:0]  rf;
    logic signed [YW-1:0]   yf5_next;

    always_comb
    begin
        pair4 = (cfg.mode == awd_pkg::MODE_TUBE) ? tanh_pair : exp_pair;
        last4 = (cfg.mode == awd_pkg::MODE_TUBE) ? tanh_last : exp_last;
        base5_next = big4_reg ? last4 : pair4[SB-1:0];
        d4 = big4_reg ? DW'(0) : ($signed({1'b0, pair4[2*SB-1:SB]})
                                  - $signed({1'b0, pair4[SB-1:0]}));
        pd5_next = d4 * $signed({1'b0, f16_4_reg});
        pf = ccc4_reg * $signed({1'b0, cfg.drive});
        mf = pf[PFW-1] ? -pf : pf;
        rf = (mf + (PFW'(1) << 7)) >> 8;
        yf5_next = YW'(pf[PFW-1] ? -rf : rf);
    end

    // stage 5: interpolation and shaping select
    logic        [SB-1:0]  base5_reg;
    logic signed [PDW-1:0] pd5_reg;
    logic signed [YW-1:0]  yf5_reg;
    logic signed [XW-1:0]  x5_reg;
    logic signed [CW-1:0]  c5_reg;

    logic        [PDW-1:0] md;
    logic        [PDW-1:0] rdm;
    logic signed [IW-1:0]  interp;
    logic signed [IW-1:0]  soft_y;
    logic signed [YW-1:0]  y6_next;

    always_comb
    begin
        md = pd5_reg[PDW-1] ? -pd5_reg : pd5_reg;
        rdm = (md + (PDW'(1) << 15)) >> 16;
        interp = $signed({2'b00, base5_reg}) + IW'(pd5_reg[PDW-1] ? -rdm : rdm);
        soft_y = (IW'(1) <<< F) - interp;
        unique case (cfg.mode)
            awd_pkg::MODE_TUBE:
            begin
                y6_next = x5_reg[XW-1] ? -YW'(interp) : YW'(interp);
            end
            awd_pkg::MODE_SOFT:
            begin
                y6_next = (c5_reg[CW-1] || c5_reg == '0) ? -YW'(soft_y) : YW'(soft_y);
            end
            awd_pkg::MODE_HARD:
            begin
                if (x5_reg > (XW'(1) <<< (F - 1)))
                    y6_next = YW'(1) <<< (F - 1);
                else if (x5_reg < -(XW'(1) <<< (F - 1)))
                    y6_next = -(YW'(1) <<< (F - 1));
                else
                    y6_next = YW'(x5_reg);
            end
            awd_pkg::MODE_FUZZ:
            begin
                y6_next = yf5_reg;
            end
            default:
            begin
                y6_next = YW'(c5_reg);
            end
        endcase
    end

    // stage 6: wet/dry mix
    logic signed [YW-1:0]  y6_reg;
    logic signed [CW-1:0]  c6_reg;
    logic        [15:0]    mix6;
    logic        [15:0]    dry6;
    logic signed [ACW-1:0] acc7_next;

    always_comb
    begin
        mix6 = (cfg.mix > awd_pkg::MIX_ONE) ? awd_pkg::MIX_ONE : cfg.mix;
        dry6 = awd_pkg::MIX_ONE - mix6;
        acc7_next = ACW'(y6_reg * $signed({1'b0, mix6}))
                    + ACW'(c6_reg * $signed({1'b0, dry6}));
    end

    // stage 7: drop the mix fraction bits
    logic signed [ACW-1:0] acc7_reg;
    logic        [ACW-1:0] ma;
    logic        [ACW-1:0] ra;
    logic signed [A2W-1:0] a8_next;

    always_comb
    begin
        ma = acc7_reg[ACW-1] ? -acc7_reg : acc7_reg;
        ra = (ma + (ACW'(1) << 14)) >> 15;
        a8_next = A2W'(acc7_reg[ACW-1] ? -ra : ra);
    end

    // stage 8: output gain product
    logic signed [A2W-1:0] a8_reg;
    logic signed [POW-1:0] po9_next;

    assign po9_next = a8_reg * $signed({1'b0, cfg.out_gain});

    // stage 9: round and saturate
    logic signed [POW-1:0] po9_reg;
    logic        [POW-1:0] mo;
    logic        [POW-1:0] ro;
    logic signed [RSW-1:0] rs;
    logic signed [SB-1:0]  out_next;
    logic signed [SB-1:0]  out_reg;

    always_comb
    begin
        mo = po9_reg[POW-1] ? -po9_reg : po9_reg;
        ro = (mo + (POW'(1) << 13)) >> 14;
        rs = RSW'(po9_reg[POW-1] ? -ro : ro);
        if (rs > ((RSW'(1) <<< F) - RSW'(1)))
            out_next = {1'b0, {F{1'b1}}};
        else if (rs < -(RSW'(1) <<< F))
            out_next = {1'b1, {F{1'b0}}};
        else
            out_next = SB'(rs);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            c1_reg <= c1_next;
        end
        if (en[2])
        begin
            x2_reg  <= x2_next;
            c2_reg  <= c1_reg;
            cc2_reg <= cc2_next;
        end
        if (en[3])
        begin
            idx3_reg  <= idx3_next;
            f16_3_reg <= f16_3_next;
            big3_reg  <= big3_next;
            x3_reg    <= x2_reg;
            c3_reg    <= c2_reg;
            ccc3_reg  <= ccc3_next;
        end
        if (en[4])
        begin
            f16_4_reg <= f16_3_reg;
            big4_reg  <= big3_reg;
            x4_reg    <= x3_reg;
            c4_reg    <= c3_reg;
            ccc4_reg  <= ccc3_reg;
        end
        if (en[5])
        begin
            base5_reg <= base5_next;
            pd5_reg   <= pd5_next;
            yf5_reg   <= yf5_next;
            x5_reg    <= x4_reg;
            c5_reg    <= c4_reg;
        end
        if (en[6])
        begin
            y6_reg <= y6_next;
            c6_reg <= c5_reg;
        end
        if (en[7])
        begin
            acc7_reg <= acc7_next;
        end
        if (en[8])
        begin
            a8_reg <= a8_next;
        end
        if (en[9])
        begin
            po9_reg <= po9_next;
        end
        if (en[10])
        begin
            out_reg <= out_next;
        end
    end

    assign dout.valid      = v_reg[NST];
    assign dout.sample_out = out_reg;

    `AWD_ASSERT_IMP(a_no_take_while_fill, clk, rst_n, filling, !din.ready)
    `AWD_ASSERT_NXT(a_take_fills_stage1, clk, rst_n, din.valid && din.ready, v_reg[1])
    `AWD_ASSERT_NXT(a_stalled_stage_holds, clk, rst_n, v_reg[9] && !en[9], v_reg[9])

endmodule

`default_nettype wire

@@ tb/audio_waveshaper_distortion_tb.sv @@
`timescale 1ns / 100ps

module audio_waveshaper_distortion_tb;

    localparam int N_CURVE = 1024;
    localparam int SBITS = 24;
    localparam int FBITS = SBITS - 1;
    localparam longint UNITY = longint'(1) << FBITS;

    typedef logic signed [SBITS-1:0] sample_t;

    typedef struct {
        awd_pkg::mode_t mode;
        logic [13:0]    drive;
        sample_t        sample;
        bit             has_lit;
        sample_t        lit;
    } dir_row_t;

    localparam int N_DIR = 22;
    dir_row_t dir_rows [0:N_DIR-1] = '{
        '{awd_pkg::MODE_TUBE, 14'd1280, 24'sd0, 1'b1, 24'sd0},
        '{awd_pkg::MODE_TUBE, 14'd1280, 24'sd8388607, 1'b0, 24'sd0},
        '{awd_pkg::MODE_TUBE, 14'd1280, -24'sd8388608, 1'b0, 24'sd0},
        '{awd_pkg::MODE_TUBE, 14'd1280, 24'sd1, 1'b0, 24'sd0},
        '{awd_pkg::MODE_TUBE, 14'd1280, -24'sd1, 1'b0, 24'sd0},
        '{awd_pkg::MODE_TUBE, 14'd12800, 24'sd8388607, 1'b0, 24'sd0},
        '{awd_pkg::MODE_TUBE, 14'd12800, -24'sd3000000, 1'b0, 24'sd0},
        '{awd_pkg::MODE_SOFT, 14'd1280, 24'sd0, 1'b1, 24'sd0},
        '{awd_pkg::MODE_SOFT, 14'd1280, -24'sd1, 1'b0, 24'sd0},
        '{awd_pkg::MODE_SOFT, 14'd1280, 24'sd1, 1'b0, 24'sd0},
        '{awd_pkg::MODE_SOFT, 14'd1280, 24'sd8388607, 1'b0, 24'sd0},
        '{awd_pkg::MODE_SOFT, 14'd1280, -24'sd8388608, 1'b0, 24'sd0},
        '{awd_pkg::MODE_SOFT, 14'd12800, -24'sd8388608, 1'b0, 24'sd0},
        '{awd_pkg::MODE_HARD, 14'd1280, 24'sd8388607, 1'b1, 24'sd4194304},
        '{awd_pkg::MODE_HARD, 14'd1280, -24'sd8388608, 1'b1, -24'sd4194304},
        '{awd_pkg::MODE_HARD, 14'd256, 24'sd4194303, 1'b1, 24'sd4194303},
        '{awd_pkg::MODE_HARD, 14'd256, -24'sd4194305, 1'b1, -24'sd4194304},
        '{awd_pkg::MODE_FUZZ, 14'd1280, 24'sd0, 1'b1, 24'sd0},
        '{awd_pkg::MODE_FUZZ, 14'd1280, 24'sd8388607, 1'b0, 24'sd0},
        '{awd_pkg::MODE_FUZZ, 14'd1280, -24'sd8388608, 1'b0, 24'sd0},
        '{awd_pkg::MODE_FUZZ, 14'd12800, 24'sd5000000, 1'b0, 24'sd0},
        '{awd_pkg::MODE_FUZZ, 14'd256, -24'sd1, 1'b0, 24'sd0}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    awd_in_if #(.SAMPLE_BITS(SBITS)) din_if ();
    awd_out_if #(.SAMPLE_BITS(SBITS)) dout_if ();

    audio_waveshaper_distortion #(
        .CURVE_TABLE_ENTRIES(N_CURVE),
        .SAMPLE_BITS(SBITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .din(din_if),
        .dout(dout_if),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    longint tanh_curve [0:N_CURVE];
    longint exp_curve [0:N_CURVE];

    awd_pkg::mode_t cur_mode;
    logic [13:0]    cur_drive;
    logic [15:0]    cur_mix;
    logic [15:0]    cur_in_gain;
    logic [15:0]    cur_out_gain;

    sample_t pending_out [$];
    int      fail_count;
    int      src_idle_pct;
    int      snk_stall_pct;

    always #10 clk = ~clk;

    function automatic logic [63:0] umul_round(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        p = p >> sh;
        return p[63:0];
    endfunction

    function automatic longint smul_round(longint a, longint b, int sh);
        bit          neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r = umul_round(ua, ub, sh);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] decay_q40(logic [63:0] v);
        logic [63:0] s;
        logic [63:0] sum;
        logic [63:0] term;
        s = (v + 64'd16) >> 5;
        sum = 64'd1 << 40;
        term = 64'd1 << 40;
        for (int k = 1; k <= 16; k++)
        begin
            term = umul_round(term, s, 40) / 64'(k);
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        for (int k = 0; k < 5; k++)
        begin
            sum = umul_round(sum, sum, 40);
        end
        return sum;
    endfunction

    function automatic void build_curves();
        logic [63:0] e;
        logic [63:0] e2;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] q44;
        for (int i = 0; i <= N_CURVE; i++)
        begin
            e = decay_q40((64'(i) << 44) / N_CURVE);
            e2 = decay_q40((64'(i) << 45) / N_CURVE);
            num = (64'd1 << 40) - e2;
            den = (64'd1 << 40) + e2;
            q = (num << 22) / den;
            r = (num << 22) % den;
            q44 = (q << 22) + ((r << 22) / den);
            exp_curve[i] = longint'((e + (64'd1 << (39 - FBITS))) >> (40 - FBITS));
            tanh_curve[i] = longint'((q44 + (64'd1 << (43 - FBITS))) >> (44 - FBITS));
        end
    endfunction

    function automatic longint curve_at(bit use_tanh, longint u);
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] f16;
        longint      lo;
        longint      hi;
        if (u >= (longint'(16) << FBITS))
            return use_tanh ? tanh_curve[N_CURVE] : exp_curve[N_CURVE];
        p = 64'(u) * N_CURVE;
        idx = p >> (FBITS + 4);
        f16 = (p & ((64'd1 << (FBITS + 4)) - 1)) >> (FBITS - 12);
        if (idx >= N_CURVE)
            return use_tanh ? tanh_curve[N_CURVE] : exp_curve[N_CURVE];
        lo = use_tanh ? tanh_curve[idx] : exp_curve[idx];
        hi = use_tanh ? tanh_curve[idx+1] : exp_curve[idx+1];
        return lo + smul_round(hi - lo, longint'(f16), 16);
    endfunction

    function automatic sample_t shape_sample(sample_t smp);
        longint c;
        longint x;
        longint u;
        longint y;
        longint m;
        longint acc;
        c = smul_round(longint'(smp), longint'(cur_in_gain), 14);
        x = smul_round(c, longint'(cur_drive), 8);
        u = (x < 0) ? -x : x;
        case (cur_mode)
            awd_pkg::MODE_TUBE:
            begin
                y = curve_at(1'b1, u);
                if (x < 0)
                    y = -y;
            end
            awd_pkg::MODE_SOFT:
            begin
                y = UNITY - curve_at(1'b0, u);
                if (c <= 0)
                    y = -y;
            end
            awd_pkg::MODE_HARD:
                y = (x > UNITY / 2) ? UNITY / 2 : ((x < -UNITY / 2) ? -UNITY / 2 : x);
            default:
                y = smul_round(smul_round(smul_round(c, c, FBITS), c, FBITS),
                               longint'(cur_drive), 8);
        endcase
        m = (cur_mix > awd_pkg::MIX_ONE) ? longint'(awd_pkg::MIX_ONE) : longint'(cur_mix);
        acc = y * m + c * (32768 - m);
        acc = smul_round(acc, 1, 15);
        acc = smul_round(acc, longint'(cur_out_gain), 14);
        if (acc > UNITY - 1)
            acc = UNITY - 1;
        if (acc < -UNITY)
            acc = -UNITY;
        return sample_t'(acc);
    endfunction

    task automatic write_reg(awd_pkg::reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            awd_pkg::REG_MODE:     cur_mode = awd_pkg::mode_t'(value[1:0]);
            awd_pkg::REG_DRIVE:    cur_drive = value[13:0];
            awd_pkg::REG_MIX:      cur_mix = value[15:0];
            awd_pkg::REG_IN_GAIN:  cur_in_gain = value[15:0];
            awd_pkg::REG_OUT_GAIN: cur_out_gain = value[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        din_if.valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic send_sample(sample_t smp, bit has_lit, sample_t lit);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            din_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        din_if.valid <= 1'b1;
        din_if.sample_in <= smp;
        do
            @(posedge clk);
        while (!din_if.ready);
        pending_out = {pending_out, (has_lit ? lit : shape_sample(smp))};
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(7))
            0: return 24'sh7fffff;
            1: return -24'sh800000;
            2: return 24'sd0;
            3: return -24'sd1;
            4: return sample_t'($urandom_range(4095)) - 24'sd2048;
            default: return sample_t'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                if (pending_out.size() == 0)
                begin
                    $error("sample_out: unexpected item, actual %0d", dout_if.sample_out);
                    fail_count++;
                end
                else if (dout_if.sample_out !== pending_out[0])
                begin
                    $error("sample_out: expected %0d actual %0d",
                           pending_out[0], dout_if.sample_out);
                    fail_count++;
                    void'(pending_out.pop_front());
                end
                else
                    void'(pending_out.pop_front());
            end
            dout_if.ready <= !(snk_stall_pct > 0 && $urandom_range(99) < snk_stall_pct);
        end
    end

    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [31:0] v;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        din_if.valid = 1'b0;
        din_if.sample_in = '0;
        dout_if.ready = 1'b0;
        fail_count = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        cur_mode = awd_pkg::MODE_TUBE;
        cur_drive = awd_pkg::DRIVE_RESET;
        cur_mix = awd_pkg::MIX_RESET;
        cur_in_gain = awd_pkg::IN_GAIN_RESET;
        cur_out_gain = awd_pkg::OUT_GAIN_RESET;
        build_curves();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].mode != cur_mode || dir_rows[i].drive != cur_drive)
            begin
                drain();
                write_reg(awd_pkg::REG_MODE, 32'(dir_rows[i].mode));
                write_reg(awd_pkg::REG_DRIVE, 32'(dir_rows[i].drive));
            end
            send_sample(dir_rows[i].sample, dir_rows[i].has_lit, dir_rows[i].lit);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            case (ph % 4)
                0: begin src_idle_pct = 0; snk_stall_pct = 0; end
                1: begin src_idle_pct = 53; snk_stall_pct = 0; end
                2: begin src_idle_pct = 0; snk_stall_pct = 53; end
                default: begin src_idle_pct = 17; snk_stall_pct = 17; end
            endcase
            if (ph == 0)
            begin
                write_reg(awd_pkg::REG_MODE, 32'(awd_pkg::MODE_HARD));
                write_reg(awd_pkg::REG_DRIVE, 32'd0);
                write_reg(awd_pkg::REG_MIX, 32'd0);
                write_reg(awd_pkg::REG_IN_GAIN, 32'd0);
                write_reg(awd_pkg::REG_OUT_GAIN, 32'd0);
            end
            else if (ph == 1)
            begin
                write_reg(awd_pkg::REG_MODE, 32'(awd_pkg::MODE_FUZZ));
                write_reg(awd_pkg::REG_DRIVE, 32'h3fff);
                write_reg(awd_pkg::REG_MIX, 32'hffff);
                write_reg(awd_pkg::REG_IN_GAIN, 32'hffff);
                write_reg(awd_pkg::REG_OUT_GAIN, 32'hffff);
            end
            else
            begin
                write_reg(awd_pkg::REG_MODE, $urandom);
                v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(12800, 256);
                write_reg(awd_pkg::REG_DRIVE, v);
                v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32768);
                write_reg(awd_pkg::REG_MIX, v);
                v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32768);
                write_reg(awd_pkg::REG_IN_GAIN, v);
                v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32768);
                write_reg(awd_pkg::REG_OUT_GAIN, v);
            end
            for (int n = 0; n < 100; n++)
            begin
                if (ph == 5 && n == 50)
                begin
                    din_if.valid <= 1'b0;
                    while (pending_out.size() != 0)
                        @(posedge clk);
                end
                send_sample(rand_sample(), 1'b0, '0);
            end
        end

        din_if.valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
